// ===== sv/bsc_pkg.sv =====
// Shared types and constants for the barometric compensation block.
// Used by the top level and by the bsc_sdiv submodule; no dependencies.
package bsc_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_TEMP    = 2'd0,
		CFG_PRESS_A = 2'd1,
		CFG_PRESS_B = 2'd2,
		CFG_PRESS_C = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
	} in_t;

	typedef struct packed {
		logic signed [31:0] temp_fine;
		logic [31:0]        pressure_q24_8;
		logic               divide_by_zero;
		logic               clipped;
	} out_t;

	localparam logic [63:0] OFFSET_TFINE = 64'd128000;
	localparam logic [63:0] PRESS_BASE   = 64'd1048576;
	localparam logic [63:0] PRESS_SCALE  = 64'd3125;

	// cycles from input transfer to result at the output register
	localparam int LATENCY = 85;
	// cycles through the signed divider
	localparam int DIV_LATENCY = 66;

endpackage

// ===== sv/baro_sensor_compensation.sv =====
// Barometric temperature and pressure compensation, fully pipelined.
// Uses bsc_pkg, bsc_delay, bsc_mul64 and bsc_sdiv.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one raw temperature and
//   one raw pressure sample. Output channel out_valid/out_stall/out_data
//   returns fine temperature, Q24.8 pressure and the divide-by-zero and
//   clip flags. One result per input, in order.
//   Calibration is written through cfg_we/cfg_index/cfg_data while the
//   pipeline is empty; writes take effect on the next edge.
// Structure: a 64-step divider with chains of two-stage multipliers
//   before and after it.
// Throughput: one item per cycle while out_stall does not hold the pipeline.
// Reset: arst_n clears the valid pipeline and all calibration registers.
// Stall: while a result waits under out_stall the whole pipeline holds and
//   in_stall is raised; nothing is dropped or repeated.
module baro_sensor_compensation (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  bsc_pkg::in_t      in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output bsc_pkg::out_t     out_data,
	input  logic              cfg_we,
	input  bsc_pkg::cfg_idx_t cfg_index,
	input  logic [63:0]       cfg_data
);
	import bsc_pkg::*;

	function automatic logic [63:0] sx16(input logic [15:0] x);
		sx16 = {{48{x[15]}}, x};
	endfunction

	logic [47:0] cal_temp_q;
	logic [63:0] cal_press_a_q;
	logic [63:0] cal_press_b_q;
	logic [15:0] cal_press_c_q;

	logic              en;
	logic [LATENCY-1:0] vld_q;

	// calibration words
	logic [31:0] t1, t2x, t3x;
	logic [63:0] p1x, p2x, p3x, p4x, p5x, p6x, p7x, p8x, p9x;

	assign t1  = {16'b0, cal_temp_q[15:0]};
	assign t2x = {{16{cal_temp_q[31]}}, cal_temp_q[31:16]};
	assign t3x = {{16{cal_temp_q[47]}}, cal_temp_q[47:32]};
	assign p1x = {48'b0, cal_press_a_q[15:0]};
	assign p2x = sx16(cal_press_a_q[31:16]);
	assign p3x = sx16(cal_press_a_q[47:32]);
	assign p4x = sx16(cal_press_a_q[63:48]);
	assign p5x = sx16(cal_press_b_q[15:0]);
	assign p6x = sx16(cal_press_b_q[31:16]);
	assign p7x = sx16(cal_press_b_q[47:32]);
	assign p8x = sx16(cal_press_b_q[63:48]);
	assign p9x = sx16(cal_press_c_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_temp_q    <= '0;
			cal_press_a_q <= '0;
			cal_press_b_q <= '0;
			cal_press_c_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TEMP:    cal_temp_q    <= cfg_data[47:0];
				CFG_PRESS_A: cal_press_a_q <= cfg_data;
				CFG_PRESS_B: cal_press_b_q <= cfg_data;
				CFG_PRESS_C: cal_press_c_q <= cfg_data[15:0];
				default:     cal_temp_q    <= cal_temp_q;
			endcase
		end
	end

	// global advance: hold everything while the output register is blocked
	assign en       = !(vld_q[LATENCY-1] && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LATENCY-2:0], in_valid};
		end
	end

	// ---------------- temperature ----------------
	logic [31:0] a_s1, b_s1;
	logic [63:0] n0_s1;
	logic [31:0] prod_a, prod_b, prod_c;
	logic [31:0] tv1_s2, bb_s2, tv1_s3, tv2_s3;
	logic [31:0] tf_sum;
	logic [31:0] tf_s4;
	logic [63:0] v1_s4;

	assign prod_a = a_s1 * t2x;
	assign prod_b = b_s1 * b_s1;
	assign prod_c = bb_s2 * t3x;
	assign tf_sum = tv1_s3 + tv2_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= {15'b0, in_data.raw_temperature[19:3]} - {t1[30:0], 1'b0};
			b_s1   <= {16'b0, in_data.raw_temperature[19:4]} - t1;
			n0_s1  <= PRESS_BASE - {44'b0, in_data.raw_pressure};
			tv1_s2 <= 32'($signed(prod_a) >>> 11);
			bb_s2  <= 32'($signed(prod_b) >>> 12);
			tv1_s3 <= tv1_s2;
			tv2_s3 <= 32'($signed(prod_c) >>> 14);
			tf_s4  <= tf_sum;
			v1_s4  <= {{32{tf_sum[31]}}, tf_sum} - OFFSET_TFINE;
		end
	end

	// ---------------- pressure polynomial ----------------
	logic [63:0] sq_s6, v1p5_s6, v1p2_s6, v1p5_s8, v1p2_s8;
	logic [63:0] v2a_s8, sqp3_s8;
	logic [63:0] v2_s9, u1_s9, n0_s9;
	logic [63:0] dprod_s11, den_s11;
	logic [63:0] numa_s10, num_s12, den_s12;
	logic        dz_s12;

	bsc_mul64 u_mul_sq   (.clk, .en, .a(v1_s4), .b(v1_s4), .p(sq_s6));
	bsc_mul64 u_mul_p5   (.clk, .en, .a(v1_s4), .b(p5x),   .p(v1p5_s6));
	bsc_mul64 u_mul_p2   (.clk, .en, .a(v1_s4), .b(p2x),   .p(v1p2_s6));
	bsc_mul64 u_mul_p6   (.clk, .en, .a(sq_s6), .b(p6x),   .p(v2a_s8));
	bsc_mul64 u_mul_p3   (.clk, .en, .a(sq_s6), .b(p3x),   .p(sqp3_s8));

	bsc_delay #(.W(64), .N(2)) u_dly_p5 (.clk, .en, .d(v1p5_s6), .q(v1p5_s8));
	bsc_delay #(.W(64), .N(2)) u_dly_p2 (.clk, .en, .d(v1p2_s6), .q(v1p2_s8));
	bsc_delay #(.W(64), .N(8)) u_dly_n0 (.clk, .en, .d(n0_s1),   .q(n0_s9));

	always_ff @(posedge clk) begin
		if (en) begin
			v2_s9    <= v2a_s8 + (v1p5_s8 << 17) + (p4x << 35);
			u1_s9    <= 64'($signed(sqp3_s8) >>> 8) + (v1p2_s8 << 12) + (64'd1 << 47);
			numa_s10 <= (n0_s9 << 31) - v2_s9;
		end
	end

	bsc_mul64 u_mul_p1   (.clk, .en, .a(u1_s9),    .b(p1x),         .p(dprod_s11));
	bsc_mul64 u_mul_sc   (.clk, .en, .a(numa_s10), .b(PRESS_SCALE), .p(num_s12));

	assign den_s11 = 64'($signed(dprod_s11) >>> 33);

	always_ff @(posedge clk) begin
		if (en) begin
			den_s12 <= den_s11;
			dz_s12  <= (den_s11 == 64'd0);
		end
	end

	// ---------------- division and final terms ----------------
	logic [63:0] q_s78, q_s80, q_s82;
	logic [63:0] ps_s78, ps_s80;
	logic [63:0] a9_s80, w1raw_s82, w2raw_s80, w2raw_s82;
	logic [63:0] sum_s83, pf_s84;
	logic        dz_s84;
	logic [31:0] tf_s84;

	bsc_sdiv u_div (.clk, .en, .num(num_s12), .den(den_s12), .quo(q_s78));

	assign ps_s78 = 64'($signed(q_s78) >>> 13);
	assign ps_s80 = 64'($signed(q_s80) >>> 13);

	bsc_mul64 u_mul_p9   (.clk, .en, .a(p9x),    .b(ps_s78), .p(a9_s80));
	bsc_mul64 u_mul_ps   (.clk, .en, .a(a9_s80), .b(ps_s80), .p(w1raw_s82));
	bsc_mul64 u_mul_p8   (.clk, .en, .a(p8x),    .b(q_s78),  .p(w2raw_s80));

	bsc_delay #(.W(64), .N(2))  u_dly_q1 (.clk, .en, .d(q_s78),     .q(q_s80));
	bsc_delay #(.W(64), .N(2))  u_dly_q2 (.clk, .en, .d(q_s80),     .q(q_s82));
	bsc_delay #(.W(64), .N(2))  u_dly_w2 (.clk, .en, .d(w2raw_s80), .q(w2raw_s82));
	bsc_delay #(.W(1),  .N(72)) u_dly_dz (.clk, .en, .d(dz_s12),    .q(dz_s84));
	bsc_delay #(.W(32), .N(80)) u_dly_tf (.clk, .en, .d(tf_s4),     .q(tf_s84));

	out_t out_d;
	out_t out_s85;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s83 <= q_s82 + 64'($signed(w1raw_s82) >>> 25)
			           + 64'($signed(w2raw_s82) >>> 19);
			pf_s84  <= 64'($signed(sum_s83) >>> 8) + (p7x << 4);
			out_s85 <= out_d;
		end
	end

	always_comb begin
		out_d.temp_fine      = tf_s84;
		out_d.divide_by_zero = dz_s84;
		out_d.clipped        = 1'b0;
		out_d.pressure_q24_8 = pf_s84[31:0];
		priority if (dz_s84) begin
			out_d.pressure_q24_8 = '0;
		end else if (pf_s84[63]) begin
			out_d.pressure_q24_8 = '0;
			out_d.clipped        = 1'b1;
		end else if (|pf_s84[62:32]) begin
			out_d.pressure_q24_8 = '1;
			out_d.clipped        = 1'b1;
		end
	end

	assign out_valid = vld_q[LATENCY-1];
	assign out_data  = out_s85;

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_q[0])
		else $error("accepted item did not enter the pipeline");

	a_dz_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.divide_by_zero |->
			out_data.pressure_q24_8 == 32'd0 && !out_data.clipped)
		else $error("divide by zero result not forced to zero");

	a_clip_rails: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.clipped |->
			out_data.pressure_q24_8 == 32'd0 || out_data.pressure_q24_8 == 32'hFFFF_FFFF)
		else $error("clipped pressure not at a rail");
endmodule

// ===== sv/bsc_delay.sv =====
// Enabled shift line that keeps pipeline side data in step with the datapath.
// Depends on nothing.
module bsc_delay #(
	parameter int W = 64,
	parameter int N = 2
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] line_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[N-1];
endmodule

// ===== sv/bsc_mul64.sv =====
// Two-stage 64x64 multiplier keeping the low 64 bits (two's complement wrap).
// Built from three 32x32 partial products; depends on nothing.
module bsc_mul64 (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);
	logic [63:0] ll_d;
	logic [31:0] lh_d;
	logic [31:0] hl_d;
	logic [63:0] ll_s1;
	logic [31:0] lh_s1;
	logic [31:0] hl_s1;
	logic [63:0] p_s2;

	assign ll_d = 64'(a[31:0]) * 64'(b[31:0]);
	assign lh_d = a[31:0] * b[63:32];
	assign hl_d = a[63:32] * b[31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= ll_d;
			lh_s1 <= lh_d;
			hl_s1 <= hl_d;
			p_s2  <= ll_s1 + {lh_s1 + hl_s1, 32'b0};
		end
	end

	assign p = p_s2;
endmodule

// ===== sv/bsc_sdiv.sv =====
// Pipelined signed 64-bit divider, quotient truncated toward zero.
// One restoring step per stage; imports bsc_pkg.
module bsc_sdiv (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic [63:0] quo
);
	import bsc_pkg::*;

	logic [63:0] rem_s [65];
	logic [63:0] nq_s  [65];
	logic [63:0] dv_s  [65];
	logic        neg_s [65];
	logic [63:0] quo_s;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			nq_s[0]  <= num[63] ? (64'd0 - num) : num;
			dv_s[0]  <= den[63] ? (64'd0 - den) : den;
			neg_s[0] <= num[63] ^ den[63];
		end
	end

	for (genvar i = 0; i < 64; i++) begin : g_step
		logic [64:0] shifted;
		logic [64:0] trial;
		assign shifted = {rem_s[i], nq_s[i][63]};
		assign trial   = shifted - {1'b0, dv_s[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= trial[64] ? shifted[63:0] : trial[63:0];
				nq_s[i+1]  <= {nq_s[i][62:0], ~trial[64]};
				dv_s[i+1]  <= dv_s[i];
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s <= neg_s[64] ? (64'd0 - nq_s[64]) : nq_s[64];
		end
	end

	assign quo = quo_s;
endmodule
